FILE: rtl/ttfd_pkg.sv
`default_nettype none
package ttfd_pkg;

    // Defaults for the top-level parameters.
    localparam int PALETTE_ENTRIES_DEF = 16384;
    localparam int MAX_DIMENSION_DEF   = 1024;

    // Fixed widths of the data path.
    localparam int COORD_W     = 13;
    localparam int SIZE_W      = 11;
    localparam int PIDX_W      = 14;
    localparam int QUEUE_DEPTH = 2;

    // Texture format codes.
    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_C4     = 4'd7;
    localparam logic [3:0] FMT_C8     = 4'd8;
    localparam logic [3:0] FMT_C14X2  = 4'd9;
    localparam logic [3:0] FMT_CMPR   = 4'd10;

    // Palette format codes.
    localparam logic [1:0] PAL_IA8    = 2'd0;
    localparam logic [1:0] PAL_RGB565 = 2'd1;
    localparam logic [1:0] PAL_RGB5A3 = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEX_FMT = 2'd0;
    localparam logic [1:0] CFG_PAL_FMT = 2'd1;
    localparam logic [1:0] CFG_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_HEIGHT  = 2'd3;

    // One queued job: a chunk to decode or a palette write.
    typedef struct packed {
        logic                is_pal;
        logic [3:0]          fmt;
        logic [1:0]          pal_fmt;
        logic [63:0]         data;
        logic [63:0]         ar;
        logic [COORD_W-1:0]  bx;
        logic [COORD_W-1:0]  by;
        logic [SIZE_W-1:0]   cur_w;
        logic [SIZE_W-1:0]   cur_h;
        logic [PIDX_W-1:0]   pal_idx;
        logic [15:0]         pal_val;
    } t_job;

    function automatic logic [7:0] ex3(input logic [2:0] v);
        return {v, v, v[2:1]};
    endfunction

    function automatic logic [7:0] ex4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] ex5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] ex6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [31:0] rgba(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [31:0] col_565(input logic [15:0] v);
        return rgba(ex5(v[15:11]), ex6(v[10:5]), ex5(v[4:0]), 8'hFF);
    endfunction

    function automatic logic [31:0] col_5a3(input logic [15:0] v);
        if (v[15]) begin
            return rgba(ex5(v[14:10]), ex5(v[9:5]), ex5(v[4:0]), 8'hFF);
        end
        return rgba(ex4(v[11:8]), ex4(v[7:4]), ex4(v[3:0]), ex3(v[14:12]));
    endfunction

    // Palette entry to color; the fourth code gives zero.
    function automatic logic [31:0] pal_color(input logic [1:0] pf, input logic [15:0] e);
        logic [31:0] c;
        case (pf)
            PAL_IA8:    c = rgba(e[7:0], e[7:0], e[7:0], e[15:8]);
            PAL_RGB565: c = col_565(e);
            PAL_RGB5A3: c = col_5a3(e);
            default:    c = 32'd0;
        endcase
        return c;
    endfunction

    // Byte k of a chunk, byte 0 in the top bits.
    function automatic logic [7:0] byte_of(input logic [63:0] w, input logic [2:0] k);
        return 8'(w >> {~k, 3'b000});
    endfunction

    // Offset of texel t inside the chunk's footprint: dx in [4:2], dy in [1:0].
    function automatic logic [4:0] texel_offset(input logic [3:0] fmt, input logic [3:0] t);
        logic [4:0] o;
        case (fmt)
            FMT_I4, FMT_C4:         o = {t[2:0], 1'b0, t[3]};
            FMT_I8, FMT_IA4, FMT_C8: o = {t[2:0], 2'b00};
            FMT_CMPR:               o = {1'b0, t[1:0], t[3:2]};
            default:                o = {1'b0, t[1:0], 2'b00};
        endcase
        return o;
    endfunction

    // Index of the last texel a chunk of this format produces.
    function automatic logic [3:0] texel_last(input logic [3:0] fmt);
        logic [3:0] n;
        case (fmt)
            FMT_I4, FMT_C4, FMT_CMPR: n = 4'd15;
            FMT_I8, FMT_IA4, FMT_C8:  n = 4'd7;
            default:                  n = 4'd3;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/tiled_texture_format_decoder.sv
`default_nettype none
// Tiled texture decoder. The input channel (i_valid / o_stall) takes one item per
// accepted edge: either an 8-byte texture chunk in storage order or, with
// i_command high, one palette entry write. The output channel (o_valid / i_stall)
// gives one RGBA8 texel per accepted edge with its x,y position; o_last_of_chunk
// marks the final texel of a chunk. Texels outside the image give no item.
// Configuration is a plain write port (format, palette format, width, height),
// to be written by the user only while the block is idle; the block does not enforce this.
// A chunk yields 4, 8 or 16 texels, one per cycle unless the receiver stalls;
// the texel expander sets the rate. When the block is idle, the first texel is
// registered in the job queue, then in the expander, then in the output stage
// that drives o_valid. A two-entry job queue sits between the walk logic and
// the expander, so new chunks are taken while earlier texels still wait.
// Palette writes pass through the job queue and produce no item.
// Reset clears the configuration to its defaults and the tile walk to the first
// tile; palette and RGBA8 buffer contents are undefined until written.
// When the receiver stalls, the shown texel holds and the expander waits; the
// queue then fills and o_stall rises.
module tiled_texture_format_decoder #(
    parameter int PALETTE_ENTRIES = ttfd_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_DIMENSION   = ttfd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [ttfd_pkg::SIZE_W-1:0] i_cfg_data,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_command,
    input  wire logic                        i_frame_start,
    input  wire logic [63:0]                 i_chunk_bytes,
    input  wire logic [ttfd_pkg::PIDX_W-1:0] i_palette_index,
    input  wire logic [15:0]                 i_palette_value,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [9:0]                       o_texel_x,
    output logic [9:0]                       o_texel_y,
    output logic [31:0]                      o_color_rgba,
    output logic                             o_last_of_chunk
);
    logic           push, q_full, q_valid, q_pop;
    ttfd_pkg::t_job push_job, head_job;

    ttfd_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .i_command       (i_command),
        .i_frame_start   (i_frame_start),
        .i_chunk_bytes   (i_chunk_bytes),
        .i_palette_index (i_palette_index),
        .i_palette_value (i_palette_value),
        .i_q_full        (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_job           (push_job)
    );

    ttfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    ttfd_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_job         (head_job),
        .o_q_pop         (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_texel_x       (o_texel_x),
        .o_texel_y       (o_texel_y),
        .o_color_rgba    (o_color_rgba),
        .o_last_of_chunk (o_last_of_chunk)
    );

endmodule
`default_nettype wire

FILE: rtl/ttfd_front.sv
`default_nettype none
module ttfd_front #(
    parameter int MAX_DIMENSION = ttfd_pkg::MAX_DIMENSION_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_index,
    input  wire logic [ttfd_pkg::SIZE_W-1:0]   i_cfg_data,
    input  wire logic                          i_valid,
    input  wire logic                          i_command,
    input  wire logic                          i_frame_start,
    input  wire logic [63:0]                   i_chunk_bytes,
    input  wire logic [ttfd_pkg::PIDX_W-1:0]   i_palette_index,
    input  wire logic [15:0]                   i_palette_value,
    input  wire logic                          i_q_full,
    output logic                               o_stall,
    output logic                               o_push,
    output ttfd_pkg::t_job                     o_job
);
    localparam int TCW = $clog2(MAX_DIMENSION / 4);
    localparam int CW  = ttfd_pkg::COORD_W;
    localparam int SW  = ttfd_pkg::SIZE_W;

    logic [3:0]    r_tex_fmt;
    logic [1:0]    r_pal_fmt;
    logic [SW-1:0] r_width;
    logic [SW-1:0] r_height;
    logic [TCW-1:0] r_col, n_col;
    logic [TCW-1:0] r_row, n_row;
    logic [2:0]    r_cit, n_cit;
    logic [63:0]   r_ar [4];

    logic          accept;
    logic          known;
    logic          tw8, th8, cpt8, fill, tile_done;
    logic [TCW-1:0] col, row;
    logic [2:0]    cit, c;
    logic [SW-1:0] cur_w, cur_h;
    logic [CW-1:0] x0, y0, bx, by, across, down, col_inc, row_inc;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Clamp the configured size to the supported maximum.
    assign cur_w = ({2'b00, r_width} > CW'(MAX_DIMENSION)) ? SW'(MAX_DIMENSION) : r_width;
    assign cur_h = ({2'b00, r_height} > CW'(MAX_DIMENSION)) ? SW'(MAX_DIMENSION) : r_height;

    // Classify the chunk and place it in the tile walk.
    always_comb begin
        col   = i_frame_start ? '0 : r_col;
        row   = i_frame_start ? '0 : r_row;
        cit   = i_frame_start ? '0 : r_cit;
        known = (r_tex_fmt <= ttfd_pkg::FMT_CMPR);
        tw8   = (r_tex_fmt <= ttfd_pkg::FMT_IA4) || (r_tex_fmt == ttfd_pkg::FMT_C4) ||
                (r_tex_fmt == ttfd_pkg::FMT_C8) || (r_tex_fmt == ttfd_pkg::FMT_CMPR);
        th8   = (r_tex_fmt == ttfd_pkg::FMT_I4) || (r_tex_fmt == ttfd_pkg::FMT_C4) ||
                (r_tex_fmt == ttfd_pkg::FMT_CMPR);
        cpt8  = (r_tex_fmt == ttfd_pkg::FMT_RGBA8);
        c     = cpt8 ? cit : {1'b0, cit[1:0]};
        x0    = tw8 ? (CW'(col) << 3) : (CW'(col) << 2);
        y0    = th8 ? (CW'(row) << 3) : (CW'(row) << 2);
        fill  = cpt8 && !c[2];
        bx    = x0;
        by    = y0 + CW'(c);
        case (r_tex_fmt)
            ttfd_pkg::FMT_I4, ttfd_pkg::FMT_C4: begin
                by = y0 + CW'({c, 1'b0});
            end
            ttfd_pkg::FMT_RGBA8: begin
                by = y0 + CW'(c[1:0]);
            end
            ttfd_pkg::FMT_CMPR: begin
                bx = x0 + CW'({c[0], 2'b00});
                by = y0 + CW'({c[1], 2'b00});
            end
            default: begin
                by = y0 + CW'(c);
            end
        endcase
        tile_done = cpt8 ? (c == 3'd7) : (c == 3'd3);
        across    = tw8 ? ((CW'(cur_w) + CW'(7)) >> 3) : ((CW'(cur_w) + CW'(3)) >> 2);
        down      = th8 ? ((CW'(cur_h) + CW'(7)) >> 3) : ((CW'(cur_h) + CW'(3)) >> 2);
        col_inc   = CW'(col) + CW'(1);
        row_inc   = CW'(row) + CW'(1);
        n_col     = col;
        n_row     = row;
        n_cit     = cit;
        if (known) begin
            if (tile_done) begin
                n_cit = '0;
                if (col_inc >= across) begin
                    n_col = '0;
                    n_row = (row_inc >= down) ? '0 : TCW'(row_inc);
                end else begin
                    n_col = TCW'(col_inc);
                end
            end else begin
                n_cit = c + 3'd1;
            end
        end
    end

    // Job handed to the back end.
    always_comb begin
        o_push          = accept && (i_command || (known && !fill));
        o_job.is_pal    = i_command;
        o_job.fmt       = r_tex_fmt;
        o_job.pal_fmt   = r_pal_fmt;
        o_job.data      = i_chunk_bytes;
        o_job.ar        = r_ar[c[1:0]];
        o_job.bx        = bx;
        o_job.by        = by;
        o_job.cur_w     = cur_w;
        o_job.cur_h     = cur_h;
        o_job.pal_idx   = i_palette_index;
        o_job.pal_val   = i_palette_value;
    end

    // Configuration and walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_fmt <= ttfd_pkg::FMT_I4;
            r_pal_fmt <= ttfd_pkg::PAL_IA8;
            r_width   <= SW'(1024);
            r_height  <= SW'(1024);
            r_col     <= '0;
            r_row     <= '0;
            r_cit     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ttfd_pkg::CFG_TEX_FMT: r_tex_fmt <= i_cfg_data[3:0];
                    ttfd_pkg::CFG_PAL_FMT: r_pal_fmt <= i_cfg_data[1:0];
                    ttfd_pkg::CFG_WIDTH:   r_width   <= i_cfg_data;
                    ttfd_pkg::CFG_HEIGHT:  r_height  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept && !i_command) begin
                r_col <= n_col;
                r_row <= n_row;
                r_cit <= n_cit;
            end
        end
    end

    // The alpha-red half of an RGBA8 tile waits here for its green-blue half.
    always_ff @(posedge i_clk) begin
        if (accept && !i_command && known && fill) begin
            r_ar[c[1:0]] <= i_chunk_bytes;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ttfd_queue.sv
`default_nettype none
module ttfd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  ttfd_pkg::t_job      i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_valid,
    output ttfd_pkg::t_job      o_job
);
    localparam int AW = $clog2(ttfd_pkg::QUEUE_DEPTH);

    ttfd_pkg::t_job r_ent [ttfd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(ttfd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_ent[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(ttfd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(ttfd_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ttfd_back.sv
`default_nettype none
module ttfd_back #(
    parameter int PALETTE_ENTRIES = ttfd_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  ttfd_pkg::t_job      i_q_job,
    output logic                o_q_pop,
    input  wire logic           i_stall,
    output logic                o_valid,
    output logic [9:0]          o_texel_x,
    output logic [9:0]          o_texel_y,
    output logic [31:0]         o_color_rgba,
    output logic                o_last_of_chunk
);
    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int CW = ttfd_pkg::COORD_W;
    localparam int IW = ttfd_pkg::PIDX_W;

    // Job being expanded.
    logic          r_busy;
    logic [3:0]    r_t, r_tlast;
    logic [3:0]    r_fmt;
    logic [1:0]    r_pal_fmt;
    logic [63:0]   r_data, r_ar;
    logic [CW-1:0] r_bx, r_by;
    logic [15:0]   r_vis, n_vis;
    logic [31:0]   r_cpal [4];
    logic [31:0]   n_cpal [4];

    // Output stage.
    logic          r_ov;
    logic [9:0]    r_ox, r_oy;
    logic [31:0]   r_color;
    logic          r_use_pal, r_oob, r_last;
    logic [1:0]    r_opal_fmt;
    logic [15:0]   r_pal_q;
    logic [15:0]   r_pal_mem [PALETTE_ENTRIES];

    logic          adv, ending, free, load, pwr;
    logic [4:0]    off;
    logic [CW-1:0] cx, cy;
    logic [31:0]   color;
    logic          use_pal;
    logic [IW-1:0] pidx;
    logic          last;

    function automatic logic [7:0] blend38(input logic [7:0] a, input logic [7:0] b);
        logic [10:0] s;
        s = 11'(a) * 11'd3 + 11'(b) * 11'd5;
        return s[10:3];
    endfunction

    function automatic logic [7:0] avg(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = 9'(a) + 9'(b);
        return s[8:1];
    endfunction

    assign adv     = r_busy && (!r_ov || !i_stall);
    assign ending  = adv && (r_t == r_tlast);
    assign free    = !r_busy || ending;
    assign o_q_pop = free && i_q_valid;
    assign load    = o_q_pop && !i_q_job.is_pal;
    assign pwr     = o_q_pop && i_q_job.is_pal &&
                     ({1'b0, i_q_job.pal_idx} < (IW+1)'(PALETTE_ENTRIES));

    // Visibility of each texel and the CMPR color set, worked out at load.
    always_comb begin
        logic [4:0]  o;
        logic [3:0]  tl;
        logic [15:0] c1, c2;
        logic [7:0]  r1, g1, b1, r2, g2, b2;
        tl = ttfd_pkg::texel_last(i_q_job.fmt);
        for (int k = 0; k < 16; k++) begin
            o = ttfd_pkg::texel_offset(i_q_job.fmt, 4'(k));
            n_vis[k] = (4'(k) <= tl) &&
                       ((i_q_job.bx + CW'(o[4:2])) < CW'(i_q_job.cur_w)) &&
                       ((i_q_job.by + CW'(o[1:0])) < CW'(i_q_job.cur_h));
        end
        c1 = i_q_job.data[63:48];
        c2 = i_q_job.data[47:32];
        r1 = ttfd_pkg::ex5(c1[15:11]);
        g1 = ttfd_pkg::ex6(c1[10:5]);
        b1 = ttfd_pkg::ex5(c1[4:0]);
        r2 = ttfd_pkg::ex5(c2[15:11]);
        g2 = ttfd_pkg::ex6(c2[10:5]);
        b2 = ttfd_pkg::ex5(c2[4:0]);
        n_cpal[0] = ttfd_pkg::rgba(r1, g1, b1, 8'hFF);
        n_cpal[1] = ttfd_pkg::rgba(r2, g2, b2, 8'hFF);
        if (c1 > c2) begin
            n_cpal[2] = ttfd_pkg::rgba(blend38(r2, r1), blend38(g2, g1), blend38(b2, b1), 8'hFF);
            n_cpal[3] = ttfd_pkg::rgba(blend38(r1, r2), blend38(g1, g2), blend38(b1, b2), 8'hFF);
        end else begin
            n_cpal[2] = ttfd_pkg::rgba(avg(r1, r2), avg(g1, g2), avg(b1, b2), 8'hFF);
            n_cpal[3] = ttfd_pkg::rgba(avg(r1, r2), avg(g1, g2), avg(b1, b2), 8'h00);
        end
    end

    // Decode of the current texel.
    always_comb begin
        logic [7:0]  b4, b8, sb, arh, arl, wh, wl;
        logic [3:0]  nib;
        logic [15:0] v;
        logic [1:0]  sel;
        off  = ttfd_pkg::texel_offset(r_fmt, r_t);
        cx   = r_bx + CW'(off[4:2]);
        cy   = r_by + CW'(off[1:0]);
        b4   = ttfd_pkg::byte_of(r_data, r_t[3:1]);
        nib  = r_t[0] ? b4[3:0] : b4[7:4];
        b8   = ttfd_pkg::byte_of(r_data, r_t[2:0]);
        wh   = ttfd_pkg::byte_of(r_data, {r_t[1:0], 1'b0});
        wl   = ttfd_pkg::byte_of(r_data, {r_t[1:0], 1'b1});
        arh  = ttfd_pkg::byte_of(r_ar, {r_t[1:0], 1'b0});
        arl  = ttfd_pkg::byte_of(r_ar, {r_t[1:0], 1'b1});
        v    = {wh, wl};
        sb   = ttfd_pkg::byte_of(r_data, {1'b1, r_t[3:2]});
        sel  = 2'(sb >> {~r_t[1:0], 1'b0});
        color   = 32'd0;
        use_pal = 1'b0;
        pidx    = '0;
        case (r_fmt)
            ttfd_pkg::FMT_I4:     color = {4{ttfd_pkg::ex4(nib)}};
            ttfd_pkg::FMT_I8:     color = {4{b8}};
            ttfd_pkg::FMT_IA4:    color = ttfd_pkg::rgba(ttfd_pkg::ex4(b8[3:0]),
                                      ttfd_pkg::ex4(b8[3:0]), ttfd_pkg::ex4(b8[3:0]),
                                      ttfd_pkg::ex4(b8[7:4]));
            ttfd_pkg::FMT_IA8:    color = ttfd_pkg::rgba(v[7:0], v[7:0], v[7:0], v[15:8]);
            ttfd_pkg::FMT_RGB565: color = ttfd_pkg::col_565(v);
            ttfd_pkg::FMT_RGB5A3: color = ttfd_pkg::col_5a3(v);
            ttfd_pkg::FMT_RGBA8:  color = ttfd_pkg::rgba(arl, wh, wl, arh);
            ttfd_pkg::FMT_C4: begin
                use_pal = 1'b1;
                pidx    = IW'(nib);
            end
            ttfd_pkg::FMT_C8: begin
                use_pal = 1'b1;
                pidx    = IW'(b8);
            end
            ttfd_pkg::FMT_C14X2: begin
                use_pal = 1'b1;
                pidx    = v[IW-1:0];
            end
            default:              color = r_cpal[sel];
        endcase
        last = (((r_vis >> r_t) >> 1) == 16'd0);
    end

    // Job sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_t    <= '0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_t    <= '0;
            end else if (ending) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_t <= r_t + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tlast   <= ttfd_pkg::texel_last(i_q_job.fmt);
            r_fmt     <= i_q_job.fmt;
            r_pal_fmt <= i_q_job.pal_fmt;
            r_data    <= i_q_job.data;
            r_ar      <= i_q_job.ar;
            r_bx      <= i_q_job.bx;
            r_by      <= i_q_job.by;
            r_vis     <= n_vis;
            r_cpal    <= n_cpal;
        end
    end

    // Output register; suppressed texels pass without taking a slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            r_ov <= adv && r_vis[r_t];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ox       <= cx[9:0];
            r_oy       <= cy[9:0];
            r_color    <= color;
            r_use_pal  <= use_pal;
            r_oob      <= ({1'b0, pidx} >= (IW+1)'(PALETTE_ENTRIES));
            r_last     <= last;
            r_opal_fmt <= r_pal_fmt;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (pwr) begin
            r_pal_mem[i_q_job.pal_idx[PW-1:0]] <= i_q_job.pal_val;
        end
        if (adv) begin
            r_pal_q <= r_pal_mem[pidx[PW-1:0]];
        end
    end

    assign o_valid         = r_ov;
    assign o_texel_x       = r_ox;
    assign o_texel_y       = r_oy;
    assign o_last_of_chunk = r_last;
    assign o_color_rgba    = r_use_pal ?
                             ttfd_pkg::pal_color(r_opal_fmt, r_oob ? 16'd0 : r_pal_q) : r_color;

endmodule
`default_nettype wire
